// ===== design/texture_address_mode_sampler_top_defines.svh =====
// assertion macros for the texture address mode sampler
// included by the modules that carry concurrent checks; no other dependencies
`ifndef TEXTURE_ADDRESS_MODE_SAMPLER_TOP_DEFINES_SVH
`define TEXTURE_ADDRESS_MODE_SAMPLER_TOP_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define TAMS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TAMS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define TAMS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)

`define TAMS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/tams_pkg.sv =====
// types and fixed constants for the texture address mode sampler
// no dependencies
package tams_pkg;

   // texel store geometry, set by the 16-bit texel index of a write request
   localparam int unsigned ADDR_W          = 16;
   localparam int unsigned TEXEL_CAPACITY  = 1 << ADDR_W;
   localparam int unsigned TEXEL_W         = 32;

   // texture size registers
   localparam int unsigned SZ_W            = 9;
   localparam int unsigned SZ_MAX          = (1 << SZ_W) - 1;

   // coordinates
   localparam int unsigned COORD_W         = 32;

   // configuration register indexes
   localparam int unsigned CSR_ADDR_W      = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDRESS_MODE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TEX_WIDTH    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TEX_HEIGHT   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_BORDER_RGBA  = 2'd3;

   // request kinds
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   typedef enum logic [2:0] {
      MODE_REPEAT    = 3'd0,
      MODE_CLAMP     = 3'd1,
      MODE_MIRROR_U  = 3'd2,
      MODE_MIRROR_V  = 3'd3,
      MODE_MIRROR_UV = 3'd4,
      MODE_BORDER    = 3'd5,
      MODE_BLANK     = 3'd6
   } mode_type;

endpackage

// ===== design/texture_address_mode_sampler_top.sv =====
// texture sampler with repeat, clamp, mirror, border and blank addressing over an rgba8 store
// depends on tams_pkg and texture_address_mode_sampler_top_defines.svh
//
//  channel  | ports                       | content (lowest bits first)
//  ---------+-----------------------------+------------------------------------------------
//  request  | req_tvalid/tready/tdata/tuser | tdata: u_coord, v_coord, texel_addr, texel_data
//           |                             | tuser: func (0 texel write, 1 sample)
//  response | rsp_tvalid/tready/tdata/tuser | tdata: red, green, blue, alpha; tuser: from_border
//  config   | csr_we/csr_addr/csr_wdata   | 0 address_mode, 1 tex_width, 2 tex_height, 3 border
//
// one request per clock while the response register is empty or being taken; a sample answers, a write answers never
// pipeline: input reg, coordinate fold, index multiply, address multiply-add, store read, output
// the texel store is a single-port memory; writes land in the same stage the reads use, so
// requests see the store in request order
// the whole pipeline advances when the response register is empty or being taken
// synchronous reset clears valid bits and configuration; the store is not cleared
`include "texture_address_mode_sampler_top_defines.svh"

module texture_address_mode_sampler_top #(
   parameter int unsigned MAX_DIM         = 256,
   parameter int unsigned COORD_FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [111:0]                           req_tdata,  // u_coord, v_coord, texel_addr, texel_data
   input  logic                                   req_tuser,  // func
   // response channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [31:0]                            rsp_tdata,  // red, green, blue, alpha
   output logic                                   rsp_tuser,  // from_border
   // configuration writes
   input  logic                                   csr_we,
   input  logic [tams_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [31:0]                            csr_wdata
);
   import tams_pkg::*;

   // fold result width: a border coordinate keeps its 31 magnitude bits
   localparam int unsigned F_W    = COORD_W - 1;
   localparam int unsigned PROD_W = F_W + SZ_W;
   localparam int unsigned IDX_W  = PROD_W - COORD_FRAC_BITS;
   localparam int unsigned ROW_W  = 2 * SZ_W;
   localparam logic [SZ_W-1:0] DIM_CAP = SZ_W'((MAX_DIM > SZ_MAX) ? SZ_MAX : MAX_DIM);
   localparam logic [F_W-1:0]  ONE     = F_W'(1) << COORD_FRAC_BITS;

   // ------------------------------------------------------------------ configuration
   logic [2:0]         address_mode_ff;
   logic [SZ_W-1:0]    tex_width_ff;    // held already limited to 1..cap
   logic [SZ_W-1:0]    tex_height_ff;
   logic [TEXEL_W-1:0] border_rgba_ff;
   logic [SZ_W-1:0]    size_in;

   always_comb begin
      size_in = csr_wdata[SZ_W-1:0];
      if (size_in == '0) begin
         size_in = SZ_W'(1);
      end else if (size_in > DIM_CAP) begin
         size_in = DIM_CAP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_mode_ff <= MODE_BLANK;
         tex_width_ff    <= SZ_W'(1);
         tex_height_ff   <= SZ_W'(1);
         border_rgba_ff  <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_ADDRESS_MODE: address_mode_ff <= csr_wdata[2:0];
            CSR_TEX_WIDTH:    tex_width_ff    <= size_in;
            CSR_TEX_HEIGHT:   tex_height_ff   <= size_in;
            CSR_BORDER_RGBA:  border_rgba_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // mode decode; the unused code behaves as border
   logic mode_clamp, mode_border, mode_blank, mirror_u, mirror_v;

   always_comb begin
      mode_clamp  = 1'b0;
      mode_border = 1'b0;
      mode_blank  = 1'b0;
      mirror_u    = 1'b0;
      mirror_v    = 1'b0;
      case (address_mode_ff)
         MODE_REPEAT:    ;
         MODE_CLAMP:     mode_clamp = 1'b1;
         MODE_MIRROR_U:  mirror_u   = 1'b1;
         MODE_MIRROR_V:  mirror_v   = 1'b1;
         MODE_MIRROR_UV: begin
            mirror_u = 1'b1;
            mirror_v = 1'b1;
         end
         MODE_BLANK:     mode_blank = 1'b1;
         default:        mode_border = 1'b1;
      endcase
   end

   logic [SZ_W-1:0] width_m1, height_m1;
   assign width_m1  = tex_width_ff - SZ_W'(1);
   assign height_m1 = tex_height_ff - SZ_W'(1);

   // ------------------------------------------------------------------ flow control
   // one enable for every stage: nothing moves while a response waits unread
   logic advance;
   logic rsp_tvalid_ff;
   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = advance;

   // ------------------------------------------------------------------ stage 1: input register
   logic                s1_vld_ff;
   logic                s1_func_ff;
   logic [COORD_W-1:0]  s1_u_ff, s1_v_ff;
   logic [ADDR_W-1:0]   s1_taddr_ff;
   logic [TEXEL_W-1:0]  s1_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_func_ff  <= req_tuser;
         s1_u_ff     <= req_tdata[31:0];
         s1_v_ff     <= req_tdata[63:32];
         s1_taddr_ff <= req_tdata[79:64];
         s1_tdata_ff <= req_tdata[111:80];
      end
   end

   // ------------------------------------------------------------------ stage 2: fold coordinates
   // per axis fraction: wrapped, mirrored, clamped to 0..1, or passed through for border
   function automatic logic [F_W-1:0] axis_fold(input logic [COORD_W-1:0] x,
                                                input logic clamp,
                                                input logic border,
                                                input logic mirror);
      logic [F_W-1:0] frac;
      logic [F_W-1:0] f;
      frac = F_W'(x[COORD_FRAC_BITS-1:0]);
      if (border) begin
         f = x[F_W-1:0];
      end else if (clamp) begin
         if (x[COORD_W-1]) begin
            f = '0;
         end else if (x[F_W-1:0] > ONE) begin
            f = ONE;
         end else begin
            f = x[F_W-1:0];
         end
      end else if (mirror && x[COORD_FRAC_BITS]) begin
         f = ONE - frac;
      end else begin
         f = frac;
      end
      return f;
   endfunction

   logic                s2_vld_ff;
   logic                s2_func_ff;
   logic                s2_neg_ff;
   logic [F_W-1:0]      s2_fu_ff, s2_fv_ff;
   logic [ADDR_W-1:0]   s2_taddr_ff;
   logic [TEXEL_W-1:0]  s2_tdata_ff;
   logic [F_W-1:0]      fu_in, fv_in;

   assign fu_in = axis_fold(s1_u_ff, mode_clamp, mode_border, mirror_u);
   assign fv_in = axis_fold(s1_v_ff, mode_clamp, mode_border, mirror_v);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (advance) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_func_ff  <= s1_func_ff;
         s2_neg_ff   <= s1_u_ff[COORD_W-1] | s1_v_ff[COORD_W-1];
         s2_fu_ff    <= fu_in;
         s2_fv_ff    <= fv_in;
         s2_taddr_ff <= s1_taddr_ff;
         s2_tdata_ff <= s1_tdata_ff;
      end
   end

   // ------------------------------------------------------------------ stage 3: scale to index
   logic                s3_vld_ff;
   logic                s3_func_ff;
   logic                s3_neg_ff;
   logic [IDX_W-1:0]    s3_iu_ff, s3_iv_ff;
   logic [ADDR_W-1:0]   s3_taddr_ff;
   logic [TEXEL_W-1:0]  s3_tdata_ff;
   logic [PROD_W-1:0]   prod_u_in, prod_v_in;

   // index = floor(f * (size - 1))
   assign prod_u_in = PROD_W'(s2_fu_ff) * PROD_W'(width_m1);
   assign prod_v_in = PROD_W'(s2_fv_ff) * PROD_W'(height_m1);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (advance) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_func_ff  <= s2_func_ff;
         s3_neg_ff   <= s2_neg_ff;
         s3_iu_ff    <= prod_u_in[PROD_W-1:COORD_FRAC_BITS];
         s3_iv_ff    <= prod_v_in[PROD_W-1:COORD_FRAC_BITS];
         s3_taddr_ff <= s2_taddr_ff;
         s3_tdata_ff <= s2_tdata_ff;
      end
   end

   // ------------------------------------------------------------------ stage 4: store address
   logic                s4_vld_ff;
   logic                s4_func_ff;
   logic                s4_oob_ff;
   logic [ADDR_W-1:0]   s4_addr_ff;
   logic [TEXEL_W-1:0]  s4_tdata_ff;
   logic                oob_in;
   logic [ROW_W-1:0]    row_in;
   logic [ROW_W-1:0]    lin_in;
   logic [ADDR_W-1:0]   addr_in;

   // border mode: negative coordinate or index past the edge on either axis
   assign oob_in = mode_border && (s3_neg_ff
                                   || s3_iu_ff >= IDX_W'(tex_width_ff)
                                   || s3_iv_ff >= IDX_W'(tex_height_ff));

   // row * pitch + column, wrapped to the store size
   assign row_in  = ROW_W'(s3_iv_ff[SZ_W-1:0]) * ROW_W'(tex_width_ff);
   assign lin_in  = row_in + ROW_W'(s3_iu_ff[SZ_W-1:0]);
   assign addr_in = (s3_func_ff == FUNC_WRITE) ? s3_taddr_ff : lin_in[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (advance) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_func_ff  <= s3_func_ff;
         s4_oob_ff   <= oob_in;
         s4_addr_ff  <= addr_in;
         s4_tdata_ff <= s3_tdata_ff;
      end
   end

   // ------------------------------------------------------------------ stage 5: texel store
   logic [TEXEL_W-1:0] texel_mem [TEXEL_CAPACITY];
   logic               s5_vld_ff;
   logic               s5_func_ff;
   logic               s5_oob_ff;
   logic [TEXEL_W-1:0] s5_rdata_ff;

   always_ff @(posedge clock) begin
      if (advance && s4_vld_ff && s4_func_ff == FUNC_WRITE) begin
         texel_mem[s4_addr_ff] <= s4_tdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_rdata_ff <= texel_mem[s4_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (advance) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_func_ff <= s4_func_ff;
         s5_oob_ff  <= s4_oob_ff;
      end
   end

   // ------------------------------------------------------------------ response register
   logic [TEXEL_W-1:0] rsp_tdata_ff;
   logic               rsp_tuser_ff;
   logic [TEXEL_W-1:0] rgba_in;
   logic               border_in;

   always_comb begin
      if (mode_blank) begin
         rgba_in   = '0;
         border_in = 1'b1;
      end else if (s5_oob_ff) begin
         rgba_in   = border_rgba_ff;
         border_in = 1'b1;
      end else begin
         rgba_in   = s5_rdata_ff;
         border_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         rsp_tvalid_ff <= s5_vld_ff && s5_func_ff == FUNC_SAMPLE;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_tdata_ff <= rgba_in;
         rsp_tuser_ff <= border_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // ------------------------------------------------------------------ checks
   // blank mode answers transparent black flagged as border
   `TAMS_ASSERT_IMP(a_blank_black, clock, reset, rsp_tvalid_ff && mode_blank, rsp_tdata_ff == '0 && rsp_tuser_ff, "blank mode gave a coloured response")
   // a texel write leaving the store stage never produces a response
   `TAMS_ASSERT_NXT(a_write_silent, clock, reset, advance && s5_vld_ff && s5_func_ff == FUNC_WRITE, !rsp_tvalid_ff, "texel write produced a response")
   // wrapped, mirrored and clamped indexes stay inside the texture
   `TAMS_ASSERT_IMP(a_u_in_range, clock, reset, s3_vld_ff && s3_func_ff == FUNC_SAMPLE && !mode_border, s3_iu_ff < IDX_W'(tex_width_ff), "column index beyond texture width")
   `TAMS_ASSERT_IMP(a_v_in_range, clock, reset, s3_vld_ff && s3_func_ff == FUNC_SAMPLE && !mode_border, s3_iv_ff < IDX_W'(tex_height_ff), "row index beyond texture height")

endmodule
